// File: sv/chroma_upsample_mcu_raster_defines.svh
// Assertion macros used by the checker file of chroma_upsample_mcu_raster.
// Each macro expects aclk and aresetn in scope at the point of use.
`ifndef CHROMA_UPSAMPLE_MCU_RASTER_DEFINES_SVH
`define CHROMA_UPSAMPLE_MCU_RASTER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define CUP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cup_pkg.sv
// Package for chroma_upsample_mcu_raster: constants, command and status types,
// and the small lookup functions used by the front module. No dependencies.
package cup_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int STORE_DEPTH   = 256;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int LINE_LEN      = 8;
    localparam int COL_W         = $clog2(LINE_LEN);
    localparam int FACTOR_LIMIT  = 4;
    localparam int MAX_BLOCKS_DEF = 4;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = 1;
    localparam int Q_CNT_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HORIZ = 2'd0,
        REG_VERT  = 2'd1,
        REG_BWIDE = 2'd2,
        REG_BHIGH = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_ERR = 2'd0,
        CMD_UPS = 2'd1,
        CMD_ROW = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                           kind;
        logic [PIX_W-1:0]                    sample;
        logic [LINE_LEN-1:0][PIX_W-1:0]      line;
        logic [CFG_W-1:0]                    h;
        logic [CFG_W-1:0]                    v;
        logic [CFG_W-1:0]                    w;
        logic                                col7;
        logic                                done;
        logic [1:0]                          base_blk;
        logic [2:0]                          base_row;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } mem_wr_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic has_row;
    } q_stat_t;

    // Lines per MCU in upsample mode: ceil(8 * blocks / hv).
    function automatic logic [5:0] ups_lines(input logic [2:0] blocks, input logic [5:0] hv);
        logic [5:0] lines;
        case (hv)
            6'd2: lines = {1'b0, blocks, 2'b00};
            6'd4: lines = {2'b00, blocks, 1'b0};
            6'd3: begin
                case (blocks)
                    3'd1:    lines = 6'd3;
                    3'd2:    lines = 6'd6;
                    3'd3:    lines = 6'd8;
                    3'd4:    lines = 6'd11;
                    default: lines = 6'd0;
                endcase
            end
            default: lines = {blocks, 3'b000};
        endcase
        return lines;
    endfunction

    // True when block b is the last block of its row of blocks.
    function automatic logic is_row_end(input logic [1:0] b, input logic [2:0] w);
        logic res;
        case (w)
            3'd1:    res = 1'b1;
            3'd2:    res = b[0];
            3'd3:    res = (b == 2'd2);
            3'd4:    res = (b == 2'd3);
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: sv/cup_front.sv
// Front part: configuration registers, input position tracking, store writes
// and classification of items into commands. Depends on cup_pkg.
module cup_front #(
    parameter int MAX_BLOCKS = cup_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cup_pkg::PIX_W-1:0]     s_tdata,   // [7:0] sample
    input  logic                          s_tuser,   // [0] mcu_start
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cup_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cup_pkg::CFG_W-1:0]     cfg_data,
    input  cup_pkg::q_stat_t              q_stat,
    input  logic                          back_row,
    output logic                          push,
    output cup_pkg::cmd_t                 push_cmd,
    output cup_pkg::mem_wr_t              mem_wr
);
    import cup_pkg::*;

    logic [CFG_W-1:0]  hf_reg, hf_next, vf_reg, vf_next;
    logic [CFG_W-1:0]  bw_reg, bw_next, bh_reg, bh_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [PIX_W-1:0]  line_reg [LINE_LEN];

    logic                           accept, cfg_bad, reorder, row_end, done;
    logic [ADDR_W-1:0]              p0, p, waddr;
    logic [5:0]                     hv, blocks_p, lines;
    logic [2:0]                     blocks;
    logic [ADDR_W:0]                total, lim;
    logic [COL_W-1:0]               col;
    logic [LINE_LEN-1:0][PIX_W-1:0] line_snap;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full && !q_stat.has_row && !back_row;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        p0       = s_tuser ? '0 : pos_reg;
        hv       = {3'b000, hf_reg} * {3'b000, vf_reg};
        blocks_p = {3'b000, bw_reg} * {3'b000, bh_reg};
        cfg_bad  = (hf_reg == '0) || (vf_reg == '0) || (bw_reg == '0) || (bh_reg == '0) ||
                   (hv > 6'(FACTOR_LIMIT)) || (blocks_p > 6'(MAX_BLOCKS));
        blocks   = blocks_p[2:0];
        reorder  = (hf_reg == 3'd1) && (vf_reg == 3'd1);
        total    = {blocks, 6'b000000};
        lines    = ups_lines(blocks, hv);
        lim      = reorder ? total : {lines, 3'b000};
        p        = ({1'b0, p0} >= lim) ? '0 : p0;
        col      = p[COL_W-1:0];
        row_end  = reorder && (col == 3'd7) && is_row_end(p[7:6], bw_reg);
        if (reorder) begin
            done = ({1'b0, p} == total - 9'd1);
        end else begin
            done = (col == 3'd7) && (({1'b0, p[7:3]} + 6'd1) == lines);
        end
        waddr = reorder ? p : {5'b00000, col};
        for (int i = 0; i < LINE_LEN; i++) begin
            line_snap[i] = line_reg[i];
        end
        line_snap[col] = s_tdata;
    end

    always_comb begin
        if (cfg_bad) begin
            push_cmd.kind = CMD_ERR;
        end else if (reorder) begin
            push_cmd.kind = CMD_ROW;
        end else begin
            push_cmd.kind = CMD_UPS;
        end
        push_cmd.sample   = s_tdata;
        push_cmd.line     = line_snap;
        push_cmd.h        = hf_reg;
        push_cmd.v        = vf_reg;
        push_cmd.w        = bw_reg;
        push_cmd.col7     = (col == 3'd7);
        push_cmd.done     = done && !cfg_bad;
        push_cmd.base_blk = p[7:6] + 2'd1 - bw_reg[1:0];
        push_cmd.base_row = p[5:3];
        push = accept && (cfg_bad || !reorder || row_end);
        mem_wr.en   = accept && !cfg_bad;
        mem_wr.addr = waddr;
        mem_wr.data = s_tdata;
    end

    always_comb begin
        hf_next  = hf_reg;
        vf_next  = vf_reg;
        bw_next  = bw_reg;
        bh_next  = bh_reg;
        pos_next = pos_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_HORIZ: hf_next = cfg_data;
                REG_VERT:  vf_next = cfg_data;
                REG_BWIDE: bw_next = cfg_data;
                REG_BHIGH: bh_next = cfg_data;
            endcase
        end
        if (accept) begin
            if (cfg_bad) begin
                pos_next = p0;
            end else begin
                pos_next = done ? '0 : p + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hf_reg  <= 3'd1;
            vf_reg  <= 3'd1;
            bw_reg  <= 3'd1;
            bh_reg  <= 3'd1;
            pos_reg <= '0;
        end else begin
            hf_reg  <= hf_next;
            vf_reg  <= vf_next;
            bw_reg  <= bw_next;
            bh_reg  <= bh_next;
            pos_reg <= pos_next;
        end
    end

    // Mirror of store entries 0..7, snapshotted into upsample commands
    always_ff @(posedge aclk) begin
        if (mem_wr.en && (mem_wr.addr[ADDR_W-1:COL_W] == '0)) begin
            line_reg[mem_wr.addr[COL_W-1:0]] <= mem_wr.data;
        end
    end

endmodule

// File: sv/cup_fifo.sv
// Two-entry command queue between the front and back parts.
// Depends on cup_pkg.
module cup_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cup_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output cup_pkg::cmd_t    head,
    output cup_pkg::q_stat_t q_stat
);
    import cup_pkg::*;

    cmd_t               ent_reg [Q_DEPTH];
    logic [Q_DEPTH-1:0] vld_reg, vld_next;
    logic [Q_PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign head = ent_reg[rp_reg];

    always_comb begin
        q_stat.empty   = (cnt_reg == '0);
        q_stat.full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
        q_stat.has_row = 1'b0;
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (vld_reg[i] && (ent_reg[i].kind == CMD_ROW)) begin
                q_stat.has_row = 1'b1;
            end
        end
    end

    always_comb begin
        vld_next = vld_reg;
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (pop) begin
            vld_next[rp_reg] = 1'b0;
            rp_next          = rp_reg + 1'b1;
        end
        if (push) begin
            vld_next[wp_reg] = 1'b1;
            wp_next          = wp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/cup_back.sv
// Back part: holds the sample store, expands one command at a time into
// result items and drives the output register. Depends on cup_pkg.
module cup_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cup_pkg::cmd_t             head,
    input  cup_pkg::q_stat_t          q_stat,
    output logic                      pop,
    input  cup_pkg::mem_wr_t          mem_wr,
    output logic                      back_row,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [cup_pkg::PIX_W-1:0] m_tdata,   // [7:0] pixel
    output logic                      m_tlast,   // run_last
    output logic [1:0]                m_tuser    // [0] mcu_end, [1] config_error
);
    import cup_pkg::*;

    logic [PIX_W-1:0]  store [STORE_DEPTH];

    cmd_t              cmd_reg;
    logic              active_reg, active_next;
    logic [1:0]        rep_reg, rep_next, s_reg, s_next, c_reg, c_next;
    logic [2:0]        k_reg, k_next;
    logic              ov_reg, ov_next;
    logic [PIX_W-1:0]  opix_reg, rdata_reg;
    logic              omem_reg, olast_reg, oend_reg, oerr_reg;

    logic              issue, s_end, k_end, c_end, rep_end;
    logic              t_last, t_mem, t_err;
    logic [PIX_W-1:0]  t_pix;
    logic [ADDR_W-1:0] t_addr;

    assign pop      = !active_reg && !q_stat.empty;
    assign issue    = active_reg && (!ov_reg || m_tready);
    assign back_row = active_reg && (cmd_reg.kind == CMD_ROW);

    assign s_end   = ({1'b0, s_reg} == cmd_reg.h - 3'd1);
    assign k_end   = (k_reg == 3'd7);
    assign c_end   = ({1'b0, c_reg} == cmd_reg.w - 3'd1);
    assign rep_end = ({1'b0, rep_reg} == cmd_reg.v - 3'd1);

    always_comb begin
        t_pix  = '0;
        t_last = 1'b1;
        t_mem  = 1'b0;
        t_err  = 1'b0;
        t_addr = {cmd_reg.base_blk + c_reg, cmd_reg.base_row, k_reg};
        rep_next = rep_reg;
        s_next   = s_reg;
        k_next   = k_reg;
        c_next   = c_reg;
        unique case (cmd_reg.kind)
            CMD_ERR: begin
                t_err = 1'b1;
            end
            CMD_UPS: begin
                if (rep_reg == 2'd0) begin
                    t_pix  = cmd_reg.sample;
                    t_last = s_end && (!cmd_reg.col7 || (cmd_reg.v == 3'd1));
                end else begin
                    t_pix  = cmd_reg.line[k_reg];
                    t_last = rep_end && k_end && s_end;
                end
                if (s_end) begin
                    s_next = '0;
                    if (rep_reg == 2'd0) begin
                        rep_next = 2'd1;
                        k_next   = '0;
                    end else if (k_end) begin
                        k_next   = '0;
                        rep_next = rep_reg + 2'd1;
                    end else begin
                        k_next = k_reg + 3'd1;
                    end
                end else begin
                    s_next = s_reg + 2'd1;
                end
            end
            CMD_ROW: begin
                t_mem  = 1'b1;
                t_last = c_end && k_end;
                k_next = k_reg + 3'd1;
                if (k_end) begin
                    c_next = c_reg + 2'd1;
                end
            end
            default: begin
                t_err = 1'b1;
            end
        endcase
    end

    always_comb begin
        active_next = active_reg;
        if (pop) begin
            active_next = 1'b1;
        end else if (issue && t_last) begin
            active_next = 1'b0;
        end
        if (issue) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end else begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head;
            rep_reg <= '0;
            s_reg   <= '0;
            k_reg   <= '0;
            c_reg   <= '0;
        end else if (issue) begin
            rep_reg <= rep_next;
            s_reg   <= s_next;
            k_reg   <= k_next;
            c_reg   <= c_next;
        end
        if (issue) begin
            opix_reg  <= t_pix;
            omem_reg  <= t_mem;
            olast_reg <= t_last;
            oend_reg  <= t_last && cmd_reg.done;
            oerr_reg  <= t_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            store[mem_wr.addr] <= mem_wr.data;
        end
        if (issue && t_mem) begin
            rdata_reg <= store[t_addr];
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = omem_reg ? rdata_reg : opix_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = {oerr_reg, oend_reg};

endmodule

// File: sv/chroma_upsample_mcu_raster.sv
// A result leaves through the command queue, command register and output register in turn;
// results of one command leave at one per cycle while m_tready is high. An item with results
// is loaded by the back as one command (1 to 32 results); an item with none (reorder, mid-line)
// pushes no command. No item is taken while a row command is queued or read out.
// Up to three items run ahead of the output: two in the command queue, one being expanded.
// Synchronous reset: config registers to 1, position 0, queue and output empty, store kept.
module chroma_upsample_mcu_raster #(
    parameter int MAX_BLOCKS = cup_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cup_pkg::PIX_W-1:0]     s_tdata,   // [7:0] sample
    input  logic                          s_tuser,   // [0] mcu_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cup_pkg::PIX_W-1:0]     m_tdata,   // [7:0] pixel
    output logic                          m_tlast,   // run_last
    output logic [1:0]                    m_tuser,   // [0] mcu_end, [1] config_error
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cup_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cup_pkg::CFG_W-1:0]     cfg_data
);
    import cup_pkg::*;

    q_stat_t q_stat;
    cmd_t    push_cmd, head;
    mem_wr_t mem_wr;
    logic    push, pop, back_row;

    cup_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .back_row  (back_row),
        .push      (push),
        .push_cmd  (push_cmd),
        .mem_wr    (mem_wr)
    );

    cup_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    cup_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .mem_wr   (mem_wr),
        .back_row (back_row),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: sv/cup_checker.sv
// Port-level checks on the result channel of chroma_upsample_mcu_raster, bound to the top.
// Depends on chroma_upsample_mcu_raster_defines.svh.
`include "chroma_upsample_mcu_raster_defines.svh"

module cup_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    `CUP_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `CUP_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `CUP_ASSERT(a_err_form, m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'd0) && !m_tuser[0], "malformed error result")
    `CUP_ASSERT(a_end_last, m_tvalid && m_tuser[0] |-> m_tlast, "MCU end without last of run")

endmodule

bind chroma_upsample_mcu_raster cup_checker u_cup_checker (.*);

// File: sim/tb_chroma_upsample_mcu_raster.sv
// Testbench for chroma_upsample_mcu_raster: directed and random items against an
// in-bench model of the upsample, raster reorder and rejected-setting paths, checked item by item.
// Depends on cup_pkg and the block itself.
`timescale 1ns / 100ps

module tb_chroma_upsample_mcu_raster;
    import cup_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_BLK = 4;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             mcu_end;
        logic             cfg_err;
    } pix_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata = '0;     // [7:0] sample
    logic               s_tuser = 1'b0;   // [0] mcu_start
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [PIX_W-1:0]   m_tdata;          // [7:0] pixel
    logic               m_tlast;
    logic [1:0]         m_tuser;          // [0] mcu_end, [1] config_error
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    reg_idx_t           cfg_index = REG_HORIZ;
    logic [CFG_W-1:0]   cfg_data = '0;

    // model state
    logic [PIX_W-1:0]   px_store [STORE_DEPTH];
    bit                 px_written [STORE_DEPTH];
    int unsigned        in_pos;
    logic [CFG_W-1:0]   cfg_h, cfg_v, cfg_bw, cfg_bh;

    pix_result_t        pending_px [$];
    pix_result_t        want;
    int                 n_errors;
    int                 rand_items;
    int                 sink_stall;
    int                 cycle_cnt;
    bit                 src_gaps;
    bit                 sink_gaps;

    chroma_upsample_mcu_raster #(
        .MAX_BLOCKS (MAX_BLK)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_chroma_upsample_mcu_raster: done, errors");
            $finish;
        end
    end

    function automatic bit cfg_rejected();
        int unsigned h, v, w, bh;
        h = 32'(cfg_h);
        v = 32'(cfg_v);
        w = 32'(cfg_bw);
        bh = 32'(cfg_bh);
        return (h == 0 || v == 0 || w == 0 || bh == 0 || h * v > FACTOR_LIMIT ||
                w * bh > MAX_BLK);
    endfunction

    // 1 when continuing at the current position would read a never-written store entry
    function automatic bit start_needed();
        int unsigned h, v, w, bh, total, lines, p, b, q, r, c, k, x, idx;
        h = 32'(cfg_h);
        v = 32'(cfg_v);
        w = 32'(cfg_bw);
        bh = 32'(cfg_bh);
        if (cfg_rejected())
            return 1'b0;
        total = 64 * w * bh;
        p = in_pos;
        if (h == 1 && v == 1) begin
            if (p >= total) p = 0;
            b = p >> 6;
            q = p & 63;
            r = q >> 3;
            if ((q & 7) == 7 && (b % w) == w - 1) begin
                for (c = 0; c < w; c++) begin
                    for (k = 0; k < 8; k++) begin
                        idx = (((b / w) * w + c) * 64 + r * 8 + k) & 255;
                        if (idx != (p & 255) && !px_written[idx])
                            return 1'b1;
                    end
                end
            end
        end else begin
            lines = (total + 8 * h * v - 1) / (8 * h * v);
            if (p >= lines * 8) p = 0;
            if ((p & 7) == 7 && v > 1) begin
                for (x = 0; x < 8 * h; x++) begin
                    idx = (x / h) & 7;
                    if (idx != 7 && !px_written[idx])
                        return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_item(input logic [PIX_W-1:0] smp, input logic st);
        int unsigned h, v, w, bh, total, p, b, q, r, n, lines, col, c, k, i, rep, x;
        logic [PIX_W-1:0] pix_buf [32];
        bit done;
        h = 32'(cfg_h);
        v = 32'(cfg_v);
        w = 32'(cfg_bw);
        bh = 32'(cfg_bh);
        n = 0;
        done = 1'b0;
        if (st) in_pos = 0;
        if (cfg_rejected()) begin
            pending_px.push_back('{pixel: '0, last: 1'b1, mcu_end: 1'b0, cfg_err: 1'b1});
            return;
        end
        total = 64 * w * bh;
        p = in_pos;
        if (h == 1 && v == 1) begin
            if (p >= total) p = 0;
            px_store[p & 255] = smp;
            px_written[p & 255] = 1'b1;
            b = p >> 6;
            q = p & 63;
            r = q >> 3;
            if ((q & 7) == 7 && (b % w) == w - 1) begin
                for (c = 0; c < w; c++) begin
                    for (k = 0; k < 8; k++) begin
                        pix_buf[n] = px_store[(((b / w) * w + c) * 64 + r * 8 + k) & 255];
                        n++;
                    end
                end
            end
            done = (p == total - 1);
        end else begin
            lines = (total + 8 * h * v - 1) / (8 * h * v);
            if (p >= lines * 8) p = 0;
            col = p & 7;
            px_store[col] = smp;
            px_written[col] = 1'b1;
            for (i = 0; i < h; i++) begin
                pix_buf[n] = smp;
                n++;
            end
            if (col == 7) begin
                for (rep = 1; rep < v; rep++) begin
                    for (x = 0; x < 8 * h; x++) begin
                        pix_buf[n] = px_store[(x / h) & 7];
                        n++;
                    end
                end
                done = ((p >> 3) + 1 == lines);
            end
        end
        in_pos = done ? 0 : ((p + 1) & 255);
        for (i = 0; i < n; i++)
            pending_px.push_back('{pixel: pix_buf[i], last: (i + 1 == n),
                                   mcu_end: (i + 1 == n) && done, cfg_err: 1'b0});
    endfunction

    function automatic void check_field(input string fname, input logic [PIX_W-1:0] exp_v,
                                        input logic [PIX_W-1:0] got_v);
        if (got_v !== exp_v) begin
            n_errors++;
            if (n_errors <= 100)
                $display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, got_v);
        end
    endfunction

    // result sink: random stalls, checks each accepted item against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                n_errors++;
                if (n_errors <= 100)
                    $display("%0t: unexpected item, expected none, got pixel %0d last %0b user %b",
                             $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_px.pop_front();
                check_field("pixel", want.pixel, m_tdata);
                check_field("run_last", PIX_W'(want.last), PIX_W'(m_tlast));
                check_field("mcu_end", PIX_W'(want.mcu_end), PIX_W'(m_tuser[0]));
                check_field("config_error", PIX_W'(want.cfg_err), PIX_W'(m_tuser[1]));
            end
            sink_stall = sink_gaps ? $urandom_range(0, 9) : 0;
        end
        if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [PIX_W-1:0] smp, input logic st);
        int gap;
        gap = src_gaps ? $urandom_range(0, 9) : 0;
        if (!st && start_needed())
            st = 1'b1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= st;
        do @(posedge aclk); while (!s_tready);
        predict_item(smp, st);
    endtask

    task automatic send_run(input int count, input bit lead_start, input bit noise);
        int i;
        for (i = 0; i < count; i++) begin
            send_item(PIX_W'($urandom_range(0, 255)),
                      (i == 0 && lead_start) || (noise && $urandom_range(0, 31) == 0));
            rand_items++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] v,
                              input logic [CFG_W-1:0] bw, input logic [CFG_W-1:0] bh);
        logic [CFG_W-1:0] vals [4];
        int i;
        vals = '{h, v, bw, bh};
        wait_drained();
        for (i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (reg_idx_t'(i))
                REG_HORIZ: cfg_h = vals[i];
                REG_VERT:  cfg_v = vals[i];
                REG_BWIDE: cfg_bw = vals[i];
                REG_BHIGH: cfg_bh = vals[i];
                default:   ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        logic [PIX_W-1:0] pat [8] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE};
        int i;
        src_gaps = 1;
        sink_gaps = 1;
        // widest horizontal replication
        set_config(3'd4, 3'd1, 3'd1, 3'd1);
        for (i = 0; i < 8; i++) send_item(pat[i], i == 0);
        // tallest vertical replication: last sample of the line brings 25 pixels
        set_config(3'd1, 3'd4, 3'd1, 3'd1);
        for (i = 0; i < 8; i++) send_item(~pat[i], i == 0);
        // reorder, one block: silent until the line completes
        set_config(3'd1, 3'd1, 3'd1, 3'd1);
        for (i = 0; i < 8; i++) send_item(pat[7 - i], i == 0);
        // rejected settings
        set_config(3'd4, 3'd2, 3'd1, 3'd1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        set_config(3'd2, 3'd2, 3'd4, 3'd4);
        send_item(8'h5A, 1'b0);
        set_config(3'd0, 3'd1, 3'd1, 3'd1);
        send_item(8'hA5, 1'b1);
        set_config(3'd7, 3'd7, 3'd7, 3'd7);
        send_item(8'h3C, 1'b0);
        set_config(3'd1, 3'd1, 3'd0, 3'd3);
        send_item(8'hC3, 1'b1);
    endtask

    // four block rows configured and three sent, then a switch to four blocks across mid-MCU (32-pixel rows)
    task automatic test_reorder_block_rows();
        src_gaps = 1;
        sink_gaps = 1;
        set_config(3'd1, 3'd1, 3'd1, 3'd4);
        send_run(192, 1'b1, 1'b0);
        set_config(3'd1, 3'd1, 3'd4, 3'd1);
        send_run(64, 1'b0, 1'b0);
    endtask

    task automatic test_random_mix(input int target);
        int kind, len, bw, bh;
        int unsigned total, lines;
        logic [CFG_W-1:0] fh, fv;
        while (rand_items < target) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                set_config(CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 7)),
                           CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 7)));
                src_gaps = $urandom_range(0, 3) != 0;
                sink_gaps = $urandom_range(0, 3) != 0;
                send_run($urandom_range(1, 3), $urandom_range(0, 1) != 0, 1'b1);
            end else begin
                bw = 1;
                bh = 1;
                if ($urandom_range(0, 3) == 0) begin
                    bw = $urandom_range(1, 4);
                    bh = $urandom_range(1, 4 / bw);
                end
                if (kind <= 3) begin
                    fh = 3'd1;
                    fv = 3'd1;
                    total = 64 * bw * bh;
                end else begin
                    case ($urandom_range(0, 6))
                        0:       begin fh = 3'd2; fv = 3'd1; end
                        1:       begin fh = 3'd1; fv = 3'd2; end
                        2:       begin fh = 3'd3; fv = 3'd1; end
                        3:       begin fh = 3'd1; fv = 3'd3; end
                        4:       begin fh = 3'd4; fv = 3'd1; end
                        5:       begin fh = 3'd1; fv = 3'd4; end
                        default: begin fh = 3'd2; fv = 3'd2; end
                    endcase
                    lines = (64 * bw * bh + 8 * fh * fv - 1) / (8 * fh * fv);
                    total = lines * 8;
                end
                set_config(fh, fv, CFG_W'(bw), CFG_W'(bh));
                src_gaps = $urandom_range(0, 3) != 0;
                sink_gaps = $urandom_range(0, 3) != 0;
                len = total;
                if (len > 64) len = $urandom_range(8, 64);
                if (len > target - rand_items) len = target - rand_items;
                send_run(len, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    initial begin
        in_pos = 0;
        cfg_h = 3'd1;
        cfg_v = 3'd1;
        cfg_bw = 3'd1;
        cfg_bh = 3'd1;
        n_errors = 0;
        rand_items = 0;
        sink_stall = 0;
        cycle_cnt = 0;
        src_gaps = 0;
        sink_gaps = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_reorder_block_rows();
        test_random_mix(280);

        wait_drained();
        if (n_errors == 0)
            $display("tb_chroma_upsample_mcu_raster: done, clean");
        else
            $display("tb_chroma_upsample_mcu_raster: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/cup_pkg.sv
sv/cup_front.sv
sv/cup_fifo.sv
sv/cup_back.sv
sv/chroma_upsample_mcu_raster.sv
sv/cup_checker.sv
sim/tb_chroma_upsample_mcu_raster.sv
